// ===== src/apiir_pkg.sv =====
// Shared types and constants for the all-pole IIR filter core.
// Used by every module of the block except apiir_vmem; depends on nothing else.
package apiir_pkg;

  // Field widths of the stream payloads
  localparam int SAMPLE_W   = 16;
  localparam int IDX_W      = 5;
  localparam int COEF_W     = 25;
  localparam int DATA_W     = 32;
  localparam int TAPS_W     = 6;
  localparam int GAIN_W     = 16;

  // Packing of the input transaction
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int SAMPLE_LSB  = 0;
  localparam int IDX_LSB     = 16;
  localparam int COEF_LSB    = 21;
  localparam int TU_REQ      = 0;
  localparam int TU_BLK      = 1;

  // Request kinds carried in tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TAPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

  localparam logic [TAPS_W-1:0]        TAPS_RST = 6'd23;
  localparam logic signed [GAIN_W-1:0] GAIN_RST = 16'sd4096;

  localparam int MAX_TAPS_DEF = 32;

  // Arithmetic formats
  localparam int ACC_W     = 64;
  localparam int PROD_W    = COEF_W + DATA_W;
  localparam int FRAC_W    = 18;
  localparam int GPROD_W   = GAIN_W + DATA_W;
  localparam int GFRAC_W   = 12;

  // Datapath strobes issued by the sequencer
  typedef struct packed {
    logic load;      // start accumulator from the new sample
    logic mul_en;    // form coefficient times delay product
    logic acc_en;    // subtract registered product
    logic round_en;  // round and saturate w0
    logic gain_en;   // form gain times w0
  } mac_ctl_t;

endpackage

// ===== src/apiir_vmem.sv =====
// Synchronous single-write, single-read memory with per-entry valid bits.
// Entries never written since reset or the last clear read as zero. Uses apiir_pkg widths
// only through its parameters.
module apiir_vmem #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clr,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_r;
  logic             q_vld_r;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;

  // Store write data, register read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  // Drop all valid bits on clear, mark written entries
  always_comb begin
    vld_nxt = clr ? '0 : vld_r;
    if (wr_en) begin
      vld_nxt[wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = q_vld_r ? q_r : '0;

endmodule

// ===== src/apiir_mac.sv =====
// Multiply-accumulate datapath: feedback sum, w0 rounding and output gain.
// Sequenced by the top level through apiir_pkg::mac_ctl_t.
module apiir_mac (
  input  logic                                 clk,
  input  apiir_pkg::mac_ctl_t                  ctl,
  input  logic signed [apiir_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [apiir_pkg::COEF_W-1:0]   coef,
  input  logic signed [apiir_pkg::DATA_W-1:0]   dly,
  input  logic signed [apiir_pkg::GAIN_W-1:0]   gain,
  output logic signed [apiir_pkg::DATA_W-1:0]   w0,
  output logic signed [apiir_pkg::DATA_W-1:0]   y
);

  localparam int RND_W  = apiir_pkg::ACC_W + 1;
  localparam int WSH_W  = RND_W - apiir_pkg::FRAC_W;
  localparam int GRND_W = apiir_pkg::GPROD_W + 1;
  localparam int YSH_W  = GRND_W - apiir_pkg::GFRAC_W;

  localparam logic signed [WSH_W-1:0] W_MAX = WSH_W'(64'sd2147483647);
  localparam logic signed [WSH_W-1:0] W_MIN = WSH_W'(-64'sd2147483648);
  localparam logic signed [YSH_W-1:0] Y_MAX = YSH_W'(64'sd2147483647);
  localparam logic signed [YSH_W-1:0] Y_MIN = YSH_W'(-64'sd2147483648);

  logic signed [apiir_pkg::ACC_W-1:0]   acc_r;
  logic signed [apiir_pkg::PROD_W-1:0]  prod_r;
  logic signed [apiir_pkg::DATA_W-1:0]  w0_r;
  logic signed [apiir_pkg::GPROD_W-1:0] gp_r;

  logic signed [RND_W-1:0]              rnd;
  logic signed [WSH_W-1:0]              wsh;
  logic signed [apiir_pkg::DATA_W-1:0]  w0_sat;
  logic signed [GRND_W-1:0]             grnd;
  logic signed [YSH_W-1:0]              ysh;

  // Round w0 half up and clamp to 32 bits
  always_comb begin
    rnd = RND_W'(acc_r) + RND_W'(64'sd1 <<< (apiir_pkg::FRAC_W - 1));
    wsh = $signed(rnd[RND_W-1:apiir_pkg::FRAC_W]);
    if (wsh > W_MAX) begin
      w0_sat = apiir_pkg::DATA_W'(W_MAX);
    end else if (wsh < W_MIN) begin
      w0_sat = apiir_pkg::DATA_W'(W_MIN);
    end else begin
      w0_sat = apiir_pkg::DATA_W'(wsh);
    end
  end

  // Round the gain product half up and clamp to 32 bits
  always_comb begin
    grnd = GRND_W'(gp_r) + GRND_W'(64'sd1 <<< (apiir_pkg::GFRAC_W - 1));
    ysh  = $signed(grnd[GRND_W-1:apiir_pkg::GFRAC_W]);
    if (ysh > Y_MAX) begin
      y = apiir_pkg::DATA_W'(Y_MAX);
    end else if (ysh < Y_MIN) begin
      y = apiir_pkg::DATA_W'(Y_MIN);
    end else begin
      y = apiir_pkg::DATA_W'(ysh);
    end
  end

  // Product, accumulate, round and gain stages
  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= coef * dly;
    end
    if (ctl.load) begin
      acc_r <= apiir_pkg::ACC_W'(sample) <<< apiir_pkg::FRAC_W;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r - apiir_pkg::ACC_W'(prod_r);
    end
    if (ctl.round_en) begin
      w0_r <= w0_sat;
    end
    if (ctl.gain_en) begin
      gp_r <= gain * w0_r;
    end
  end

  assign w0 = w0_r;

endmodule

// ===== src/all_pole_iir_filter_core.sv =====
// All-pole direct-form-II IIR filter core: sequencer, memories and stream ports.
// Depends on apiir_pkg, apiir_vmem and apiir_mac.
//
// A sample transaction runs from acceptance to the result register through a walk
// over the taps, where T is the number of taps in use (taps_in_use, 0 read as 1,
// capped at MAX_TAPS): one shared multiply-accumulate walks taps 1 to T-1 at one tap
// per cycle, reading the coefficient and delay memories together and writing the
// shifted delay value back in the same pass, followed by a drain of the pending read
// and product and then the rounding, gain and output load states. With a single tap
// the walk and the drain are skipped. The input is ready again the cycle after the
// result register loads, so a new sample is not taken until the last one has
// reached it; a finished result that finds the output register still occupied and
// not being read holds the sequencer, and the input with it. A coefficient write
// leaves the block idle. A new transaction is taken while a finished result still
// waits in the output register. Both memories start out as zeros after reset
// through per-entry valid bits, and a block-start sample clears the delay line in
// the acceptance cycle, so no clearing pass is needed.
module all_pole_iir_filter_core #(
  parameter int MAX_TAPS = apiir_pkg::MAX_TAPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // [15:0] sample_in, [20:16] coeff_index, [45:21] coeff_value, [47:46] zero
  input  logic [apiir_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] req_type, [1] block_start
  input  logic [apiir_pkg::IN_TUSER_W-1:0]     in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [31:0] sample_out
  output logic [apiir_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apiir_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apiir_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = $clog2(MAX_TAPS);
  localparam int TW = $clog2(MAX_TAPS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_GAIN  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [apiir_pkg::TAPS_W-1:0]        taps_r, taps_nxt;
  logic signed [apiir_pkg::GAIN_W-1:0] gain_r, gain_nxt;
  logic [TW-1:0]                       teff, teff_r, teff_nxt;
  logic [TW-1:0]                       j_r, j_nxt;
  logic                                rd_pend_r, rd_pend_nxt;
  logic                                prod_v_r, prod_v_nxt;
  logic [AW-1:0]                       rd_idx_r;
  logic [apiir_pkg::DATA_W-1:0]        prev_r;
  logic                                out_vld_r, out_vld_nxt;
  logic [apiir_pkg::DATA_W-1:0]        out_data_r;
  logic                                out_load;

  logic                                in_acc, is_coef, blk;
  logic signed [apiir_pkg::SAMPLE_W-1:0] sample_in;
  logic [apiir_pkg::IDX_W-1:0]         coeff_index;
  logic [apiir_pkg::COEF_W-1:0]        coeff_value;

  logic                                cw_en;
  logic [AW-1:0]                       rd_addr;
  logic                                rd_en;
  logic                                dw_en;
  logic [AW-1:0]                       dw_addr;
  logic [apiir_pkg::DATA_W-1:0]        dw_data;
  logic [apiir_pkg::COEF_W-1:0]        coef_q;
  logic [apiir_pkg::DATA_W-1:0]        dly_q;
  logic signed [apiir_pkg::DATA_W-1:0] w0, y;
  apiir_pkg::mac_ctl_t                 ctl;

  // Unpack the input transaction
  assign sample_in   = $signed(in_tdata[apiir_pkg::SAMPLE_LSB +: apiir_pkg::SAMPLE_W]);
  assign coeff_index = in_tdata[apiir_pkg::IDX_LSB +: apiir_pkg::IDX_W];
  assign coeff_value = in_tdata[apiir_pkg::COEF_LSB +: apiir_pkg::COEF_W];
  assign is_coef     = (in_tuser[apiir_pkg::TU_REQ] == apiir_pkg::REQ_COEF);
  assign blk         = in_tuser[apiir_pkg::TU_BLK];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Effective tap count: zero acts as one, clamp to the store depth
  always_comb begin
    if (taps_r == '0) begin
      teff = TW'(1);
    end else if (32'(taps_r) > 32'(MAX_TAPS)) begin
      teff = TW'(MAX_TAPS);
    end else begin
      teff = TW'(taps_r);
    end
  end

  // Coefficient writes skip slot zero and slots beyond the store
  assign cw_en = in_acc && is_coef && (coeff_index != '0)
                 && (32'(coeff_index) < 32'(MAX_TAPS));

  // Configuration registers
  always_comb begin
    taps_nxt = taps_r;
    gain_nxt = gain_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        apiir_pkg::CFG_TAPS: taps_nxt = cfg_data[apiir_pkg::TAPS_W-1:0];
        apiir_pkg::CFG_GAIN: gain_nxt = $signed(cfg_data[apiir_pkg::GAIN_W-1:0]);
        default: ;
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    teff_nxt    = teff_r;
    j_nxt       = j_r;
    rd_pend_nxt = 1'b0;
    prod_v_nxt  = rd_pend_r;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    ctl         = '0;
    ctl.load    = in_acc && !is_coef;
    ctl.mul_en  = rd_pend_r;
    ctl.acc_en  = prod_v_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && !is_coef) begin
          teff_nxt  = teff;
          j_nxt     = TW'(1);
          state_nxt = (teff == TW'(1)) ? ST_ROUND : ST_RUN;
        end
      end
      ST_RUN: begin
        rd_en       = 1'b1;
        rd_pend_nxt = 1'b1;
        j_nxt       = j_r + TW'(1);
        if (j_r == teff_r - TW'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_pend_r && !prod_v_r) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctl.round_en = 1'b1;
        state_nxt    = ST_GAIN;
      end
      ST_GAIN: begin
        ctl.gain_en = 1'b1;
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (!out_vld_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign rd_addr = j_r[AW-1:0];

  // Delay write-back: shifted value during the walk, w0 into tap one at the end unless a single tap is in use
  always_comb begin
    dw_en   = 1'b0;
    dw_addr = rd_idx_r;
    dw_data = prev_r;
    if (state_r == ST_GAIN) begin
      dw_en   = (teff_r != TW'(1));
      dw_addr = AW'(1);
      dw_data = w0;
    end else if (rd_pend_r) begin
      dw_en = (rd_idx_r != AW'(1));
    end
  end

  // Output register handshake
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      taps_r    <= apiir_pkg::TAPS_RST;
      gain_r    <= apiir_pkg::GAIN_RST;
      teff_r    <= TW'(1);
      j_r       <= TW'(1);
      rd_pend_r <= 1'b0;
      prod_v_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      taps_r    <= taps_nxt;
      gain_r    <= gain_nxt;
      teff_r    <= teff_nxt;
      j_r       <= j_nxt;
      rd_pend_r <= rd_pend_nxt;
      prod_v_r  <= prod_v_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx_r <= rd_addr;
    end
    if (rd_pend_r) begin
      prev_r <= dly_q;
    end
    if (out_load) begin
      out_data_r <= y;
    end
  end

  apiir_vmem #(
    .DEPTH (MAX_TAPS),
    .WIDTH (apiir_pkg::COEF_W),
    .AW    (AW)
  ) u_coef_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (1'b0),
    .wr_en   (cw_en),
    .wr_addr (AW'(coeff_index)),
    .wr_data (coeff_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (coef_q)
  );

  apiir_vmem #(
    .DEPTH (MAX_TAPS),
    .WIDTH (apiir_pkg::DATA_W),
    .AW    (AW)
  ) u_dly_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (in_acc && !is_coef && blk),
    .wr_en   (dw_en),
    .wr_addr (dw_addr),
    .wr_data (dw_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (dly_q)
  );

  apiir_mac u_mac (
    .clk    (clk),
    .ctl    (ctl),
    .sample (sample_in),
    .coef   ($signed(coef_q)),
    .dly    ($signed(dly_q)),
    .gain   (gain_r),
    .w0     (w0),
    .y      (y)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== src/apiir_chk.sv =====
// Port-level checker for the all-pole IIR filter core, bound to the top level.
// Depends on apiir_pkg for port widths.
module apiir_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic [apiir_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [apiir_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // Keep the result channel quiet right after a reset cycle
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A sample transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[apiir_pkg::TU_REQ] == apiir_pkg::REQ_SAMPLE)
    |=> !in_tready)
    else $error("ready after accepting a sample");

  // A coefficient write leaves the block idle
  a_coef_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser[apiir_pkg::TU_REQ] == apiir_pkg::REQ_COEF)
    |=> in_tready)
    else $error("coefficient write stalled the input");

  // A new result appears only out of a busy period
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without a sample in flight");

endmodule

bind all_pole_iir_filter_core apiir_chk u_apiir_chk (.*);
